// ===== rtl/rbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbcs_pkg
// Shared types and constants of the rgb bounce color sweep block.
// ----------------------------------------------------------------------------
package rbcs_pkg;

   localparam int NUM_CHANNELS = 3;
   localparam int LEVEL_W      = 8;
   localparam int FADE_W       = 16;
   localparam int PROD_W       = LEVEL_W + FADE_W;
   localparam int QUOT_BITS    = 8;
   localparam int COUNT_W      = $clog2(QUOT_BITS);

   localparam logic [LEVEL_W-1:0] LEVEL_TOP   = 8'd255;
   localparam logic [LEVEL_W-1:0] LEVEL_START = 8'd10;
   localparam logic [LEVEL_W-1:0] STEP_START  = 8'd5;

   localparam logic [1:0] OP_ADVANCE = 2'd0;
   localparam logic [1:0] OP_BACKUP  = 2'd1;
   localparam logic [1:0] OP_RESTORE = 2'd2;
   localparam logic [1:0] OP_READ    = 2'd3;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_WRITE
   } ctl_state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               down;
      logic               moved;
   } move_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/rbcs_req_if.sv =====
// ----------------------------------------------------------------------------
// rbcs_req_if
// Command channel: opcode and fade ratio with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbcs_req_if import rbcs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [FADE_W-1:0] fade_max;
   logic [FADE_W-1:0] fade_pos;

   modport source (output valid, output opcode, output fade_max, output fade_pos,
                   input ready);
   modport sink   (input valid, input opcode, input fade_max, input fade_pos,
                   output ready);
endinterface

// ===== rtl/rbcs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rbcs_rsp_if
// Result channel: scaled red, green and blue with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbcs_rsp_if import rbcs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] red_out;
   logic [LEVEL_W-1:0] green_out;
   logic [LEVEL_W-1:0] blue_out;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

// ===== rtl/rbcs_color.sv =====
// ----------------------------------------------------------------------------
// rbcs_color
// Color state: levels, directions, save area and the odometer advance.
// ----------------------------------------------------------------------------
module rbcs_color import rbcs_pkg::*; (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [1:0]                            opcode,
   input  logic [LEVEL_W-1:0]                    step_size,
   output logic [NUM_CHANNELS-1:0][LEVEL_W-1:0]  level
);

   logic [NUM_CHANNELS-1:0][LEVEL_W-1:0] level_ff, level_in;
   logic [NUM_CHANNELS-1:0]              down_ff, down_in;
   logic [NUM_CHANNELS-1:0][LEVEL_W-1:0] saved_level_ff;
   logic [NUM_CHANNELS-1:0]              saved_down_ff;
   move_type                             mv_blue, mv_green, mv_red;

   function automatic move_type try_move(input logic [LEVEL_W-1:0] cur,
                                         input logic down,
                                         input logic [LEVEL_W-1:0] step);
      move_type           r;
      logic [LEVEL_W:0]   sum;
      sum     = {1'b0, cur} + {1'b0, step};
      r.level = cur;
      r.down  = down;
      r.moved = 1'b0;
      if (down) begin
         if (step > cur) begin
            r.down = 1'b0;
         end else begin
            r.level = cur - step;
            r.moved = 1'b1;
         end
      end else begin
         if (sum > {1'b0, LEVEL_TOP}) begin
            r.down = 1'b1;
         end else begin
            r.level = sum[LEVEL_W-1:0];
            r.moved = 1'b1;
         end
      end
      return r;
   endfunction

   always_comb begin
      mv_blue  = try_move(level_ff[CH_BLUE], down_ff[CH_BLUE], step_size);
      mv_green = try_move(level_ff[CH_GREEN], down_ff[CH_GREEN], step_size);
      mv_red   = try_move(level_ff[CH_RED], down_ff[CH_RED], step_size);
      level_in = level_ff;
      down_in  = down_ff;
      case (opcode)
         OP_ADVANCE: begin
            level_in[CH_BLUE] = mv_blue.level;
            down_in[CH_BLUE]  = mv_blue.down;
            if (!mv_blue.moved) begin
               level_in[CH_GREEN] = mv_green.level;
               down_in[CH_GREEN]  = mv_green.down;
               if (!mv_green.moved) begin
                  level_in[CH_RED] = mv_red.level;
                  down_in[CH_RED]  = mv_red.down;
               end
            end
         end
         OP_RESTORE: begin
            level_in = saved_level_ff;
            down_in  = saved_down_ff;
         end
         OP_BACKUP, OP_READ: begin
            level_in = level_ff;
         end
         default: begin
            level_in = level_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff       <= {NUM_CHANNELS{LEVEL_START}};
         down_ff        <= '0;
         saved_level_ff <= {NUM_CHANNELS{LEVEL_START}};
         saved_down_ff  <= '0;
      end else if (accept) begin
         level_ff <= level_in;
         down_ff  <= down_in;
         if (opcode == OP_BACKUP) begin
            saved_level_ff <= level_ff;
            saved_down_ff  <= down_ff;
         end
      end
   end

   assign level = level_ff;

endmodule

// ===== rtl/rbcs_divider.sv =====
// ----------------------------------------------------------------------------
// rbcs_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbcs_divider import rbcs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_W-1:0]    dividend,
   input  logic [FADE_W-1:0]    divisor,
   output div_status_type       status,
   output logic [QUOT_BITS-1:0] quotient
);

   logic [FADE_W-1:0]    rem_ff, rem_in;
   logic [QUOT_BITS-1:0] low_ff, low_in;
   logic [COUNT_W-1:0]   cnt_ff;
   logic                 busy_ff, done_ff;
   logic [FADE_W:0]      trial;
   logic                 fits;

   // dividend is below 256 * divisor, so the upper bits start as remainder
   always_comb begin
      trial  = {rem_ff, low_ff[QUOT_BITS-1]};
      fits   = trial >= {1'b0, divisor};
      rem_in = fits ? FADE_W'(trial - {1'b0, divisor}) : trial[FADE_W-1:0];
      low_in = {low_ff[QUOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[PROD_W-1:QUOT_BITS];
         low_ff <= dividend[QUOT_BITS-1:0];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == COUNT_W'(QUOT_BITS - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + COUNT_W'(1);
            if (cnt_ff == COUNT_W'(QUOT_BITS - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = low_ff;

endmodule

// ===== rtl/rgb_bounce_color_sweep.sv =====
// ----------------------------------------------------------------------------
// rgb_bounce_color_sweep
// Bouncing rgb color with advance, backup, restore and faded read-out.
//
// Usage:
//   req_if carries one command per transaction (opcode, fade_max, fade_pos);
//   rsp_if returns one faded color per command. csr_wr_en/csr_wr_data write
//   the step size; write it only while no command is in flight.
//   The color state is updated at the edge that accepts the command. The
//   three channels are then scaled one after another: one 8x16 multiply
//   feeding a bit-serial divider that produces one quotient bit a cycle.
//   Each channel passes through the divider in turn; after blue the result
//   is loaded into the output register, and only then is a new command
//   taken, so commands never overlap.
//   The result sits in an output register. If the receiver stalls, the
//   block still finishes the next command and then waits holding it until
//   the output register is free.
//   Reset (synchronous, active high) sets all levels and saved levels to 10,
//   all directions to up, the step size to 5, and empties the output.
// ----------------------------------------------------------------------------
module rgb_bounce_color_sweep import rbcs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   rbcs_req_if.sink           req_if,
   rbcs_rsp_if.source         rsp_if,
   input  logic               csr_wr_en,
   input  logic [LEVEL_W-1:0] csr_wr_data
);

   ctl_state_type                        state_ff, state_in;
   logic [1:0]                           ch_ff, ch_in;
   logic [LEVEL_W-1:0]                   step_size_ff;
   logic [FADE_W-1:0]                    num_ff, den_ff;
   logic [NUM_CHANNELS-1:0][LEVEL_W-1:0] level;
   logic [LEVEL_W-1:0]                   level_sel;
   logic [PROD_W-1:0]                    product;
   logic                                 req_accept;
   logic                                 div_start;
   logic                                 out_load;
   div_status_type                       div_status;
   logic [QUOT_BITS-1:0]                 quotient;
   logic [LEVEL_W-1:0]                   red_q_ff, green_q_ff;
   logic                                 rsp_valid_ff;
   logic [LEVEL_W-1:0]                   red_out_ff, green_out_ff, blue_out_ff;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= STEP_START;
      end else if (csr_wr_en) begin
         step_size_ff <= csr_wr_data;
      end
   end

   rbcs_color u_color (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .opcode    (req_if.opcode),
      .step_size (step_size_ff),
      .level     (level)
   );

   // fade ratio
   always_ff @(posedge clock) begin
      if (req_accept) begin
         num_ff <= (req_if.fade_pos > req_if.fade_max) ? '0 : req_if.fade_pos;
         den_ff <= (req_if.fade_max == '0) ? FADE_W'(1) : req_if.fade_max;
      end
   end

   assign level_sel = level[ch_in];
   assign product   = PROD_W'(level_sel) * PROD_W'(num_ff);

   rbcs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (den_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_START;
               ch_in    = CH_RED;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (ch_ff == CH_BLUE) begin
                  if (!rsp_valid_ff || rsp_if.ready) begin
                     out_load = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end else begin
                  ch_in     = ch_ff + 2'd1;
                  div_start = 1'b1;
               end
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= CH_RED;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV && div_status.done) begin
         if (ch_ff == CH_RED) begin
            red_q_ff <= quotient;
         end
         if (ch_ff == CH_GREEN) begin
            green_q_ff <= quotient;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         red_out_ff   <= red_q_ff;
         green_out_ff <= green_q_ff;
         blue_out_ff  <= quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.red_out   = red_out_ff;
   assign rsp_if.green_out = green_out_ff;
   assign rsp_if.blue_out  = blue_out_ff;

   a_start_not_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == ST_DIV)
      else $error("divider done outside the divide state");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      ch_ff != 2'd3)
      else $error("channel index out of range");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DIV || state_ff == ST_WRITE))
      else $error("result raised without a finished transaction");

endmodule
